// File: hw/rtl/ilir_pkg.sv
// Shared types and constants for the indexed list block.
package ilir_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_PUSH   = 3'd1,
        OP_POP    = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_PUSH,
        CM_INSERT,
        CM_REMOVE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode             mode;
        logic [IDX_W-1:0]       idx;
    } t_cell_ctl;

    // Decoded transaction, ctrl -> top
    typedef struct packed {
        t_cell_ctl              cell_ctl;
        t_status                status;
        logic [CNT_W-1:0]       fill_nx;
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_idx;
    } t_dec;

endpackage

// File: hw/rtl/indexed_list_insert_remove.sv
// Indexed list top level: length register, row of shifting cells, result registers.
// Result, status and count are registered and strobed after the accepting edge.
// Throughput: one transaction per cycle for every operation; insert and remove
//   move all cells in parallel, so the row of cells keeps up with that rate.
// Reset (synchronous, active low) empties the list and clears the strobe;
//   busy is high during reset and for the cycle after it, low from then on.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_op,
    input  logic [IDX_W-1:0]     i_position,
    input  logic [WORD_W-1:0]    i_word_in,
    output logic                 o_strobe,
    output logic [WORD_W-1:0]    o_word_out,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_count
);

    // Control state
    logic               r_rdy;
    logic               r_strobe;
    logic [CNT_W-1:0]   r_fill;
    // Result payload (no reset needed)
    logic [WORD_W-1:0]  r_word;
    t_status            r_status;
    logic [CNT_W-1:0]   r_count;

    logic               accept;
    t_dec               dec;
    logic [WORD_W-1:0]  cell_word [CAPACITY];
    logic [WORD_W-1:0]  rd_data;

    assign busy   = ~r_rdy;
    assign accept = start & r_rdy;

    ilir_ctrl u_ctrl (
        .i_valid    (accept),
        .i_op       (i_op),
        .i_position (i_position),
        .i_fill     (r_fill),
        .o_dec      (dec)
    );

    // Row of cells: insert pulls from the left neighbor, remove from the right.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (k == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[k+1];
        end
        ilir_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (dec.cell_ctl),
            .i_cell_idx (IDX_W'(k)),
            .i_word     (i_word_in),
            .i_left     (left_w),
            .i_right    (right_w),
            .o_word     (cell_word[k])
        );
    end

    // Single read port: position for read, last entry for pop
    assign rd_data = cell_word[dec.rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy    <= 1'b0;
            r_strobe <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_rdy    <= 1'b1;
            r_strobe <= accept;
            r_fill   <= dec.fill_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= dec.rd_en ? rd_data : '0;
            r_status <= dec.status;
            r_count  <= dec.fill_nx;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_word_out = r_word;
    assign o_status   = r_status;
    assign o_count    = r_count;

    // Length never exceeds capacity
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill above capacity");

    // Every accepted transaction gives a strobe on the next cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("missing result strobe");

    // Errors return a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_word_out == '0))
        else $error("nonzero word on error");

    // Reported count matches the length register
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_count == r_fill))
        else $error("count differs from fill");

    // Length only moves on an accepted transaction
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rdy && !accept) |=> $stable(r_fill))
        else $error("fill changed while idle");

endmodule

// File: hw/rtl/ilir_cell.sv
// One storage cell of the list: holds one word, takes from a neighbor on shift.
module ilir_cell
    import ilir_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]     i_cell_idx,
    input  logic [WORD_W-1:0]    i_word,
    input  logic [WORD_W-1:0]    i_left,
    input  logic [WORD_W-1:0]    i_right,
    output logic [WORD_W-1:0]    o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.mode)
            CM_PUSH: begin
                if (i_cell_idx == i_ctl.idx) n_word = i_word;
            end
            CM_INSERT: begin
                if (i_cell_idx == i_ctl.idx)     n_word = i_word;
                else if (i_cell_idx > i_ctl.idx) n_word = i_left;
            end
            CM_REMOVE: begin
                if (i_cell_idx >= i_ctl.idx) n_word = i_right;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: hw/rtl/ilir_ctrl.sv
// Operation decode: range and fullness checks, new length, cell command.
module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic                 i_valid,
    input  logic [OP_W-1:0]      i_op,
    input  logic [IDX_W-1:0]     i_position,
    input  logic [CNT_W-1:0]     i_fill,
    output t_dec                 o_dec
);

    logic pos_ok;
    logic full;

    assign pos_ok = CNT_W'(i_position) < i_fill;
    assign full   = i_fill == CNT_W'(CAPACITY);

    always_comb begin
        o_dec.cell_ctl.mode = CM_HOLD;
        o_dec.cell_ctl.idx  = i_position;
        o_dec.status        = ST_OK;
        o_dec.fill_nx       = i_fill;
        o_dec.rd_en         = 1'b0;
        o_dec.rd_idx        = i_position;
        unique case (t_op'(i_op))
            OP_READ: begin
                if (pos_ok) o_dec.rd_en  = 1'b1;
                else        o_dec.status = ST_BAD;
            end
            OP_PUSH: begin
                if (full) begin
                    o_dec.status = ST_FULL;
                end else begin
                    o_dec.cell_ctl.mode = CM_PUSH;
                    o_dec.cell_ctl.idx  = i_fill[IDX_W-1:0];
                    o_dec.fill_nx       = i_fill + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (i_fill == '0) begin
                    o_dec.status = ST_BAD;
                end else begin
                    o_dec.fill_nx = i_fill - CNT_W'(1);
                    o_dec.rd_en   = 1'b1;
                    o_dec.rd_idx  = o_dec.fill_nx[IDX_W-1:0];
                end
            end
            OP_INSERT: begin
                // index checked before fullness
                if (!pos_ok) begin
                    o_dec.status = ST_BAD;
                end else if (full) begin
                    o_dec.status = ST_FULL;
                end else begin
                    o_dec.cell_ctl.mode = CM_INSERT;
                    o_dec.fill_nx       = i_fill + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!pos_ok) begin
                    o_dec.status = ST_BAD;
                end else begin
                    o_dec.cell_ctl.mode = CM_REMOVE;
                    o_dec.fill_nx       = i_fill - CNT_W'(1);
                end
            end
            default: o_dec.status = ST_BAD;
        endcase
        if (!i_valid) begin
            o_dec.cell_ctl.mode = CM_HOLD;
            o_dec.fill_nx       = i_fill;
        end
    end

endmodule

// File: sim/tb_indexed_list_insert_remove.sv
// Self-checking testbench for the indexed list block: directed table, then random traffic.
module tb_indexed_list_insert_remove
    import ilir_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes past OP_REMOVE are unused; the block must answer them with a bad status
    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
    localparam logic [WORD_W-1:0] WORD_MAX       = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN       = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_ONES      = 32'hFFFF_FFFF;
    localparam int                RANDOM_OPS     = 500;
    localparam int                QUIET_TAIL     = 100;   // last ops are sent back to back

    // One reply of the block, as it shows up on the result ports
    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_reply;

    // One line of the directed table; reps > 1 repeats the row's op with an incrementing word
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        int                reps;
        bit                typed;   // 1: reply below is written out, 0: predictor decides
        t_reply            want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op       = '0;
    logic [IDX_W-1:0]  i_position = '0;
    logic [WORD_W-1:0] i_word_in  = '0;
    logic              o_strobe;
    logic [WORD_W-1:0] o_word_out;
    logic [1:0]        o_status;
    logic [CNT_W-1:0]  o_count;

    // Shadow copy of the list contents and length
    logic [WORD_W-1:0] shadow_words [CAPACITY];
    int                shadow_fill = 0;

    t_reply owed_replies [$];   // replies still due, oldest first
    t_row   plan_rows [$];      // directed table
    int     fails   = 0;
    bit     growing = 1'b1;     // random traffic drifts toward full, then toward empty

    indexed_list_insert_remove uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_position (i_position),
        .i_word_in  (i_word_in),
        .o_strobe   (o_strobe),
        .o_word_out (o_word_out),
        .o_status   (o_status),
        .o_count    (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset held at the start of the run, then released for good
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Global watchdog: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // Applies one operation to the shadow list and returns the reply it must produce.
    function automatic t_reply apply_list_op(input logic [OP_W-1:0]   op,
                                             input logic [IDX_W-1:0]  pos,
                                             input logic [WORD_W-1:0] word);
        t_reply r;
        int     k;
        r.word   = '0;
        r.status = ST_OK;
        case (op)
            OP_READ: begin
                if (pos < shadow_fill) r.word = shadow_words[pos];
                else                   r.status = ST_BAD;
            end
            OP_PUSH: begin
                if (shadow_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            OP_POP: begin
                if (shadow_fill == 0) begin
                    r.status = ST_BAD;
                end else begin
                    shadow_fill--;
                    r.word = shadow_words[shadow_fill];
                end
            end
            OP_INSERT: begin
                // index is checked before fullness; index == length is rejected
                if (pos >= shadow_fill) begin
                    r.status = ST_BAD;
                end else if (shadow_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = shadow_fill; k > pos; k--) shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos] = word;
                    shadow_fill++;
                end
            end
            OP_REMOVE: begin
                if (pos >= shadow_fill) begin
                    r.status = ST_BAD;
                end else begin
                    for (k = pos + 1; k < shadow_fill; k++) shadow_words[k-1] = shadow_words[k];
                    shadow_fill--;
                end
            end
            default: r.status = ST_BAD;
        endcase
        r.count = shadow_fill[CNT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] pos,
                                    input logic [WORD_W-1:0] word, input int reps,
                                    input bit typed, input logic [WORD_W-1:0] w_word,
                                    input t_status w_status, input logic [CNT_W-1:0] w_count);
        t_row row;
        row.op    = op;
        row.pos   = pos;
        row.word  = word;
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{word: w_word, status: w_status, count: w_count};
        plan_rows.push_back(row);
    endfunction

    // Holds one transaction on the ports until the block takes it, then books its reply.
    // start stays high on return so back-to-back transactions need no extra edge.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] pos,
                           input logic [WORD_W-1:0] word, input bit typed, input t_reply want);
        t_reply predicted;
        start      <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_word_in  <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_list_op(op, pos, word);
        owed_replies.push_back(typed ? want : predicted);
    endtask

    // Sender idle for the pause; junk on the payload ports must be ignored
    task automatic pause(input int n);
        start      <= 1'b0;
        i_op       <= OP_W'($urandom());
        i_position <= IDX_W'($urandom());
        i_word_in  <= $urandom();
        repeat (n) @(posedge i_clk);
    endtask

    // Sender holds off until every booked reply has come back
    task automatic drain();
        start <= 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_reply            none;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        int                roll;
        bit                gappy;

        none  = '0;
        gappy = 1'b1;

        // Directed table, starting from the empty list left by reset
        add_row(OP_READ,        0, '0,        1, 1, '0,       ST_BAD, 0); // read of empty list
        add_row(OP_POP,         0, '0,        1, 1, '0,       ST_BAD, 0); // pop on empty
        add_row(OP_INSERT,      0, 32'h5A5A_5A5A, 1, 1, '0,   ST_BAD, 0); // insert into empty
        add_row(OP_REMOVE,     15, '0,        1, 1, '0,       ST_BAD, 0); // remove out of range
        add_row(OP_SPARE_FIRST, 0, '0,        1, 1, '0,       ST_BAD, 0); // unused op codes
        add_row(OP_SPARE_LAST, 15, WORD_ONES, 1, 1, '0,       ST_BAD, 0);
        add_row(OP_PUSH,        0, WORD_MAX,  1, 1, '0,       ST_OK,  1);
        add_row(OP_PUSH,       15, WORD_MIN,  1, 1, '0,       ST_OK,  2);
        add_row(OP_READ,        1, '0,        1, 1, WORD_MIN, ST_OK,  2);
        add_row(OP_READ,        2, '0,        1, 1, '0,       ST_BAD, 2); // index == length
        add_row(OP_INSERT,      2, 32'd1,     1, 1, '0,       ST_BAD, 2); // insert at length
        add_row(OP_INSERT,      0, WORD_ONES, 1, 0, '0,       ST_OK,  0);
        add_row(OP_READ,        0, '0,        1, 0, '0,       ST_OK,  0);
        add_row(OP_REMOVE,      1, '0,        1, 0, '0,       ST_OK,  0);
        add_row(OP_PUSH,        0, 32'd1000, 14, 0, '0,       ST_OK,  0); // fill to capacity
        add_row(OP_PUSH,        0, 32'h1234_5678, 1, 1, '0,   ST_FULL, 16); // push when full
        add_row(OP_INSERT,     15, WORD_ONES, 1, 1, '0,       ST_FULL, 16); // insert when full
        add_row(OP_INSERT,      0, WORD_ONES, 1, 1, '0,       ST_FULL, 16);
        add_row(OP_READ,       15, '0,        1, 0, '0,       ST_OK,  0);
        add_row(OP_REMOVE,      0, '0,        1, 0, '0,       ST_OK,  0); // shifts every entry
        add_row(OP_REMOVE,     14, '0,        1, 0, '0,       ST_OK,  0); // last entry
        add_row(OP_INSERT,     13, WORD_MIN,  1, 0, '0,       ST_OK,  0);
        add_row(OP_POP,         0, '0,        1, 0, '0,       ST_OK,  0);

        while (i_rst_n !== 1'b1) @(posedge i_clk);

        foreach (plan_rows[i]) begin
            for (int r = 0; r < plan_rows[i].reps; r++) begin
                if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
                send_op(plan_rows[i].op, plan_rows[i].pos, plan_rows[i].word + r,
                        plan_rows[i].typed, plan_rows[i].want);
            end
        end

        // Let the directed part settle completely before random traffic
        drain();

        // Random traffic: mostly legal ops with in-range indices, drifting between
        // empty and full so both ends get hammered; a few spare op codes and
        // out-of-range indices as noise.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0) gappy = 1'($urandom_range(0, 1));
            if (n == RANDOM_OPS / 2) drain();
            if (n < RANDOM_OPS - QUIET_TAIL && gappy && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 16));

            // stay a few ops at each end before turning around
            if (shadow_fill == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
            if (shadow_fill == 0 && $urandom_range(0, 2) == 0)        growing = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < 3)       op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else if (roll < 23) op = OP_READ;
            else if (growing)   op = (roll < 63) ? OP_PUSH : (roll < 88) ? OP_INSERT :
                                     (roll < 94) ? OP_POP  : OP_REMOVE;
            else                op = (roll < 53) ? OP_REMOVE : (roll < 83) ? OP_POP :
                                     (roll < 91) ? OP_PUSH   : OP_INSERT;

            if (shadow_fill > 0 && $urandom_range(0, 9) < 8)
                pos = IDX_W'($urandom_range(0, shadow_fill - 1));
            else
                pos = IDX_W'($urandom_range(0, CAPACITY - 1));

            case ($urandom_range(0, 19))
                0:       word = WORD_MAX;
                1:       word = WORD_MIN;
                2:       word = WORD_ONES;
                3:       word = '0;
                default: word = $urandom();
            endcase

            send_op(op, pos, word, 1'b0, none);
        end

        // Wait out the last replies, then keep watching for stray strobes
        drain();
        repeat (4) @(posedge i_clk);

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    function automatic void note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        fails++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    // Reply checker: each strobe is a transaction that must match the oldest booked reply
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (owed_replies.size() == 0) begin
                note_mismatch("unexpected reply, word", '0, o_word_out);
            end else begin
                want = owed_replies.pop_front();
                if (o_word_out !== want.word)
                    note_mismatch("word_out", want.word, o_word_out);
                if (o_status !== want.status)
                    note_mismatch("status", WORD_W'(want.status), WORD_W'(o_status));
                if (o_count !== want.count)
                    note_mismatch("count", WORD_W'(want.count), WORD_W'(o_count));
            end
        end
    end

endmodule
